### design/cdra_pkg.sv
// Package for the character display register addresser.
// Item types, operation codes and constants; no dependencies.
package cdra_pkg;

  localparam int unsigned CharWidth = 6;

  typedef enum logic [3:0] {
    OP_CTL_WR    = 4'd0,
    OP_MODE_WR   = 4'd1,
    OP_PAGE_ADDR = 4'd2,
    OP_HOME_ADDR = 4'd3,
    OP_PAGE_RD   = 4'd4,
    OP_PAGE_WR   = 4'd5,
    OP_CHAR_RD   = 4'd6,
    OP_CHAR_WR   = 4'd7,
    OP_COLOUR    = 4'd8
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_CTL,
    KIND_MODE,
    KIND_PAGE_ADDR,
    KIND_HOME_ADDR,
    KIND_PAGE_ACC,
    KIND_CHAR_ACC,
    KIND_COLOUR
  } cmd_kind_e;

  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_PAGE = 2'd1;
  localparam logic [1:0] REQ_CHAR = 2'd2;

  localparam logic [10:0] HOME_MASK  = 11'h7fc;
  localparam logic [10:0] PAGE_MASK  = 11'h3ff;
  localparam logic [3:0]  LINE_MASK8 = 4'h7;

  typedef struct packed {
    logic [3:0]  operation;
    logic [7:0]  byte_data;
    logic [15:0] cpu_word;
    logic [10:0] bus_offset;
    logic        page_colour_bit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mem_request;
    logic        mem_write;
    logic [10:0] page_address;
    logic [3:0]  char_line;
    logic [7:0]  write_data;
    logic        read_forced_ones;
    logic [6:0]  pen_index;
    logic [5:0]  pixel_pattern;
    logic [4:0]  lines_per_char;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        is_write;
    logic [7:0]  byte_data;
    logic [15:0] cpu_word;
    logic [10:0] bus_offset;
    logic        page_colour_bit;
  } cmd_t;

endpackage

### design/char_display_register_addresser.sv
// Top level of the character display register addresser.
// Depends on cdra_pkg, cdra_fifo, cdra_front and cdra_back.
//
// Usage:
//   Input queue port: drive in_item and push; a transaction is taken at a
//   clock edge with push high and full low.
//   Result queue port: while empty is low the oldest result is on out_item;
//   it is taken at a clock edge with pop high.
//   Config port: cfg_valid_i writes cfg_data_i into the video standard bit
//   (0 NTSC, 1 PAL); cfg_ready_o is always high. Write only while idle.
// Path: a transaction is registered in the command queue, executed by the
//   back end and registered in the result queue, from which it is popped.
// Throughput: one transaction per clock while the result queue is not full,
//   set by the back end, which moves one command per cycle between queues.
// Reset: all display registers clear, video standard goes to PAL, both
//   queues empty.
// Stall: when pop stays low the result queue fills (ResultDepth entries),
//   the back end holds, the command queue fills (CmdDepth entries) and full
//   rises; no transaction is lost.
module char_display_register_addresser
  import cdra_pkg::*;
#(
  parameter int unsigned CmdDepth    = 2,
  parameter int unsigned ResultDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  in_item_i,
  output logic      full,
  input  logic      pop,
  output out_item_t out_item_o,
  output logic      empty,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  cmd_t      cmd_in, cmd_head;
  out_item_t res;
  logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic      res_push, res_full;

  assign cfg_ready_o = 1'b1;

  cdra_front u_front (
    .push_i     (push),
    .in_item_i  (in_item_i),
    .q_full_i   (cmd_full),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  cdra_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  cdra_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_head),
    .cmd_avail_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  cdra_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (ResultDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

`ifndef SYNTHESIS
  a_cmd_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> !cmd_empty) else $error("command queue lost a transaction");

  a_res_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> !empty) else $error("result queue lost a transaction");

  a_no_write_without_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(out_item_o.mem_request == REQ_NONE && out_item_o.mem_write))
    else $error("write flag without memory request");

  a_height_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.lines_per_char == 5'd8 || out_item_o.lines_per_char == 5'd9 ||
                out_item_o.lines_per_char == 5'd16))
    else $error("illegal character height");
`endif

endmodule

### design/cdra_fifo.sv
// Small register queue with registered storage and a count.
// No dependencies; width and depth are parameters.
module cdra_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/cdra_front.sv
// Front end: takes input transactions and classifies the operation.
// Depends on cdra_pkg.
module cdra_front
  import cdra_pkg::*;
(
  input  logic     push_i,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     full_o,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  assign full_o     = q_full_i;
  assign cmd_push_o = push_i && !q_full_i;

  always_comb begin
    cmd_o.kind            = KIND_NOP;
    cmd_o.is_write        = 1'b0;
    cmd_o.byte_data       = in_item_i.byte_data;
    cmd_o.cpu_word        = in_item_i.cpu_word;
    cmd_o.bus_offset      = in_item_i.bus_offset;
    cmd_o.page_colour_bit = in_item_i.page_colour_bit;
    case (opcode_e'(in_item_i.operation))
      OP_CTL_WR:    cmd_o.kind = KIND_CTL;
      OP_MODE_WR:   cmd_o.kind = KIND_MODE;
      OP_PAGE_ADDR: cmd_o.kind = KIND_PAGE_ADDR;
      OP_HOME_ADDR: cmd_o.kind = KIND_HOME_ADDR;
      OP_PAGE_RD:   cmd_o.kind = KIND_PAGE_ACC;
      OP_PAGE_WR: begin
        cmd_o.kind     = KIND_PAGE_ACC;
        cmd_o.is_write = 1'b1;
      end
      OP_CHAR_RD:   cmd_o.kind = KIND_CHAR_ACC;
      OP_CHAR_WR: begin
        cmd_o.kind     = KIND_CHAR_ACC;
        cmd_o.is_write = 1'b1;
      end
      OP_COLOUR:    cmd_o.kind = KIND_COLOUR;
      default:      cmd_o.kind = KIND_NOP;
    endcase
  end

endmodule

### design/cdra_back.sv
// Back end: holds the display registers, executes classified commands
// and forms result transactions. Depends on cdra_pkg.
module cdra_back
  import cdra_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_data_i,
  input  cmd_t      cmd_i,
  input  logic      cmd_avail_i,
  output logic      cmd_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_item_t res_o
);

  logic        video_std_q;
  logic [2:0]  bg_colour_q, bg_colour_d;
  logic        tone_q, tone_d;
  logic        disp_off_q, disp_off_d;
  logic [1:0]  cmap_q, cmap_d;
  logic        fres_h_q, fres_h_d;
  logic        fres_v_q, fres_v_d;
  logic        access_q, access_d;
  logic        nine_q, nine_d;
  logic        sixteen_q, sixteen_d;
  logic        dpage_q, dpage_d;
  logic [10:0] page_q, page_d;
  logic [10:0] home_q, home_d;
  logic        fire;
  logic [10:0] eff_page;
  logic        cb0, cb1, pcb;
  logic        r, g, b;

  function automatic logic [4:0] char_height(logic sixteen, logic dpage, logic nine);
    if (sixteen && !dpage) begin
      return 5'd16;
    end else if (!nine) begin
      return 5'd9;
    end
    return 5'd8;
  endfunction

  assign fire       = cmd_avail_i && !res_full_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;
  assign eff_page   = dpage_q ? page_q : (page_q & PAGE_MASK);
  assign cb0        = cmd_i.byte_data[6];
  assign cb1        = cmd_i.byte_data[7];
  assign pcb        = cmd_i.page_colour_bit;

  always_comb begin
    case (cmap_q)
      2'd0: begin
        r = cb0; b = cb1; g = pcb;
      end
      2'd1: begin
        r = cb0; b = pcb; g = cb1;
      end
      default: begin
        r = pcb; b = cb0; g = cb1;
      end
    endcase
  end

  always_comb begin
    bg_colour_d = bg_colour_q;
    tone_d      = tone_q;
    disp_off_d  = disp_off_q;
    cmap_d      = cmap_q;
    fres_h_d    = fres_h_q;
    fres_v_d    = fres_v_q;
    access_d    = access_q;
    nine_d      = nine_q;
    sixteen_d   = sixteen_q;
    dpage_d     = dpage_q;
    page_d      = page_q;
    home_d      = home_q;
    res_o       = '0;

    case (cmd_i.kind)
      KIND_CTL: begin
        bg_colour_d = cmd_i.byte_data[2:0];
        tone_d      = cmd_i.byte_data[3];
        disp_off_d  = cmd_i.byte_data[4];
        cmap_d      = cmd_i.byte_data[6:5];
        fres_h_d    = cmd_i.byte_data[7];
      end
      KIND_MODE: begin
        access_d = cmd_i.cpu_word[0];
        nine_d   = cmd_i.cpu_word[3];
        if (!video_std_q) begin
          sixteen_d = cmd_i.cpu_word[5];
        end
        dpage_d  = cmd_i.cpu_word[6];
        fres_v_d = cmd_i.cpu_word[7];
        page_d   = cmd_i.cpu_word[0] ? cmd_i.cpu_word[10:0] : '0;
      end
      KIND_PAGE_ADDR: page_d = cmd_i.cpu_word[10:0];
      KIND_HOME_ADDR: home_d = cmd_i.cpu_word[10:0] & HOME_MASK;
      KIND_PAGE_ACC: begin
        res_o.mem_request  = REQ_PAGE;
        res_o.page_address = access_q ? eff_page : cmd_i.bus_offset;
        res_o.mem_write    = cmd_i.is_write;
        res_o.write_data   = cmd_i.is_write ? cmd_i.byte_data : '0;
      end
      KIND_CHAR_ACC: begin
        if (access_q) begin
          res_o.mem_request  = REQ_CHAR;
          res_o.page_address = eff_page;
          res_o.char_line    = (char_height(sixteen_q, dpage_q, nine_q) == 5'd8)
                               ? (cmd_i.bus_offset[3:0] & LINE_MASK8)
                               : cmd_i.bus_offset[3:0];
          res_o.mem_write    = cmd_i.is_write;
          res_o.write_data   = cmd_i.is_write ? cmd_i.byte_data : '0;
        end else begin
          res_o.read_forced_ones = !cmd_i.is_write;
        end
      end
      KIND_COLOUR: begin
        res_o.pen_index     = tone_q ? {4'({1'b0, bg_colour_q} + 4'd1), r, b, g}
                                     : {4'd0, r, b, g};
        res_o.pixel_pattern = cmd_i.byte_data[CharWidth-1:0];
      end
      default: ;
    endcase

    res_o.lines_per_char = char_height(sixteen_d, dpage_d, nine_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_std_q <= 1'b1;
      bg_colour_q <= '0;
      tone_q      <= 1'b0;
      disp_off_q  <= 1'b0;
      cmap_q      <= '0;
      fres_h_q    <= 1'b0;
      fres_v_q    <= 1'b0;
      access_q    <= 1'b0;
      nine_q      <= 1'b0;
      sixteen_q   <= 1'b0;
      dpage_q     <= 1'b0;
      page_q      <= '0;
      home_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        video_std_q <= cfg_data_i;
      end
      if (fire) begin
        bg_colour_q <= bg_colour_d;
        tone_q      <= tone_d;
        disp_off_q  <= disp_off_d;
        cmap_q      <= cmap_d;
        fres_h_q    <= fres_h_d;
        fres_v_q    <= fres_v_d;
        access_q    <= access_d;
        nine_q      <= nine_d;
        sixteen_q   <= sixteen_d;
        dpage_q     <= dpage_d;
        page_q      <= page_d;
        home_q      <= home_d;
      end
    end
  end

endmodule
